// File: src/clns_pkg.sv
// shared types, constants and the per-command action table of the display sequencer
package clns_pkg;

  // command op codes
  localparam logic [2:0] OP_INIT       = 3'd0;
  localparam logic [2:0] OP_CLEAR      = 3'd1;
  localparam logic [2:0] OP_CHAR       = 3'd2;
  localparam logic [2:0] OP_STRING     = 3'd3;
  localparam logic [2:0] OP_GOTO       = 3'd4;
  localparam logic [2:0] OP_CURSOR_ON  = 3'd5;
  localparam logic [2:0] OP_CURSOR_OFF = 3'd6;

  // configuration register indexes
  localparam logic REG_LINE0_BASE = 1'b0;
  localparam logic REG_LINE1_BASE = 1'b1;

  localparam logic [6:0] LINE0_BASE_RST = 7'd0;
  localparam logic [6:0] LINE1_BASE_RST = 7'd64;

  localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

  // display instruction bytes
  localparam logic [7:0] INSTR_FUNC_SET   = 8'b0010_1000;
  localparam logic [7:0] INSTR_DISP_OFF   = 8'b0000_1000;
  localparam logic [7:0] INSTR_CLEAR      = 8'b0000_0001;
  localparam logic [7:0] INSTR_CURSOR_UL  = 8'b0000_1110;
  localparam logic [7:0] INSTR_ENTRY_MODE = 8'b0000_0110;
  localparam logic [7:0] INSTR_HOME_ADDR  = 8'b1000_0000;
  localparam logic [7:0] INSTR_CURSOR_BLK = 8'b0000_1111;
  localparam logic [7:0] INSTR_CURSOR_OFF = 8'b0000_1100;

  localparam logic [3:0] NIB_WAKE = 4'h3;
  localparam logic [3:0] NIB_4BIT = 4'h2;

  // segment hold times in instruction cycles
  localparam int HOLD_W = 21;
  localparam logic [HOLD_W-1:0] HOLD_SETTLE          = 21'd7000;
  localparam logic [HOLD_W-1:0] HOLD_PULSE           = 21'd100;
  localparam logic [HOLD_W-1:0] HOLD_BYTE_END        = 21'd300;
  localparam logic [HOLD_W-1:0] HOLD_BYTE_END_INIT   = 21'd35300;
  localparam logic [HOLD_W-1:0] HOLD_BYTE_END_CLEAR  = 21'd105300;
  localparam logic [HOLD_W-1:0] HOLD_INIT_PULSE      = 21'd80;
  localparam logic [HOLD_W-1:0] HOLD_INIT_PULSE_END  = 21'd35080;
  localparam logic [HOLD_W-1:0] HOLD_POWERUP         = 21'd1550000;

  localparam int QUEUE_DEPTH = 2;

  typedef struct packed {
    logic [2:0] op;
    logic [7:0] char_code;
    logic [6:0] target_column;
    logic       target_row;
    logic       block_cursor;
  } in_word_t;

  typedef struct packed {
    logic              reg_select;
    logic              enable_pin;
    logic [3:0]        bus_value;
    logic [HOLD_W-1:0] hold_cycles;
    logic              last_segment;
  } out_word_t;

  typedef enum logic [1:0] {
    KIND_INIT,
    KIND_CLEAR,
    KIND_BYTE,
    KIND_NEWLINE
  } cmd_kind_t;

  // classified command as it travels from front to back
  typedef struct packed {
    cmd_kind_t  kind;
    logic       sel;
    logic [7:0] byte_val;
    logic       row;
    logic       set_row;
  } cmd_t;

  typedef enum logic [1:0] {
    ACT_SETTLE,
    ACT_POWERUP,
    ACT_NIBBLE,
    ACT_BYTE
  } act_code_t;

  typedef enum logic [1:0] {
    TAIL_NONE,
    TAIL_INIT,
    TAIL_CLEAR
  } tail_t;

  typedef struct packed {
    act_code_t  code;
    logic [7:0] arg;
    tail_t      tail;
    logic       last;
  } act_t;

  typedef enum logic {
    BK_IDLE,
    BK_RUN
  } back_state_t;

  localparam int PC_W = 4;

  // action list of each command kind, indexed by program step
  function automatic act_t act_decode(cmd_kind_t kind, logic [PC_W-1:0] pc,
                                      logic sel, logic [7:0] byte_val);
    act_t a;
    a.code = ACT_BYTE;
    a.arg  = INSTR_HOME_ADDR;
    a.tail = TAIL_NONE;
    a.last = 1'b1;
    unique case (kind)
      KIND_INIT: begin
        a.last = 1'b0;
        unique case (pc)
          4'd0: begin
            a.code = ACT_POWERUP;
            a.arg  = 8'h00;
          end
          4'd1, 4'd2, 4'd3: begin
            a.code = ACT_NIBBLE;
            a.arg  = {4'h0, NIB_WAKE};
          end
          4'd4: begin
            a.code = ACT_NIBBLE;
            a.arg  = {4'h0, NIB_4BIT};
          end
          4'd5: begin
            a.arg  = INSTR_FUNC_SET;
            a.tail = TAIL_INIT;
          end
          4'd6: begin
            a.arg  = INSTR_DISP_OFF;
            a.tail = TAIL_INIT;
          end
          4'd7: begin
            a.arg  = INSTR_CLEAR;
            a.tail = TAIL_INIT;
          end
          4'd8: begin
            a.arg  = INSTR_CURSOR_UL;
            a.tail = TAIL_INIT;
          end
          4'd9: begin
            a.arg  = INSTR_ENTRY_MODE;
            a.tail = TAIL_INIT;
          end
          4'd10: begin
            a.code = ACT_SETTLE;
            a.arg  = 8'h00;
          end
          4'd11: begin
            a.arg  = INSTR_CLEAR;
            a.tail = TAIL_CLEAR;
          end
          default: begin
            a.arg  = INSTR_HOME_ADDR;
            a.last = 1'b1;
          end
        endcase
      end
      KIND_CLEAR: begin
        a.last = 1'b0;
        unique case (pc)
          4'd0: begin
            a.code = ACT_SETTLE;
            a.arg  = 8'h00;
          end
          4'd1: begin
            a.arg  = INSTR_CLEAR;
            a.tail = TAIL_CLEAR;
          end
          default: begin
            a.arg  = INSTR_HOME_ADDR;
            a.last = 1'b1;
          end
        endcase
      end
      KIND_BYTE: begin
        if (pc == 4'd0) begin
          a.code = ACT_SETTLE;
          a.arg  = {7'd0, sel};
          a.last = 1'b0;
        end else begin
          a.arg  = byte_val;
        end
      end
      KIND_NEWLINE: begin
        unique case (pc)
          4'd0: begin
            a.code = ACT_SETTLE;
            a.arg  = 8'h01;
            a.last = 1'b0;
          end
          4'd1: begin
            a.code = ACT_SETTLE;
            a.arg  = 8'h00;
            a.last = 1'b0;
          end
          4'd2: begin
            a.arg  = byte_val;
            a.last = 1'b0;
          end
          default: begin
            a.code = ACT_SETTLE;
            a.arg  = 8'h01;
          end
        endcase
      end
    endcase
    return a;
  endfunction

endpackage

// File: src/clns_front.sv
// front end: takes command words and classifies them into queue entries
module clns_front (
  input  logic                 in_valid,
  output logic                 in_ready,
  input  clns_pkg::in_word_t   in_data,
  input  logic [6:0]           line0_base,
  input  logic [6:0]           line1_base,
  input  logic                 q_full,
  output logic                 q_push,
  output clns_pkg::cmd_t       q_push_data
);

  logic [6:0] base;
  logic [6:0] addr;
  logic       known;

  assign in_ready = !q_full;
  assign base     = in_data.target_row ? line1_base : line0_base;
  assign addr     = in_data.target_column + base;

  always_comb begin
    known                = 1'b1;
    q_push_data.kind     = clns_pkg::KIND_BYTE;
    q_push_data.sel      = 1'b0;
    q_push_data.byte_val = in_data.char_code;
    q_push_data.row      = in_data.target_row;
    q_push_data.set_row  = 1'b0;
    unique case (in_data.op)
      clns_pkg::OP_INIT:  q_push_data.kind = clns_pkg::KIND_INIT;
      clns_pkg::OP_CLEAR: q_push_data.kind = clns_pkg::KIND_CLEAR;
      clns_pkg::OP_CHAR:  q_push_data.sel  = 1'b1;
      clns_pkg::OP_STRING: begin
        q_push_data.sel = 1'b1;
        if (in_data.char_code == clns_pkg::CHAR_NEWLINE) begin
          q_push_data.kind = clns_pkg::KIND_NEWLINE;
        end
      end
      clns_pkg::OP_GOTO: begin
        q_push_data.byte_val = {1'b1, addr};
        q_push_data.set_row  = 1'b1;
      end
      clns_pkg::OP_CURSOR_ON: begin
        q_push_data.byte_val = in_data.block_cursor ? clns_pkg::INSTR_CURSOR_BLK
                                                    : clns_pkg::INSTR_CURSOR_UL;
      end
      clns_pkg::OP_CURSOR_OFF: q_push_data.byte_val = clns_pkg::INSTR_CURSOR_OFF;
      default: known = 1'b0;
    endcase
  end

  // undefined op is swallowed here
  assign q_push = in_valid && in_ready && known;

endmodule

// File: src/clns_queue.sv
// small command queue between the front and back ends
module clns_queue #(
  parameter int DEPTH = clns_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  clns_pkg::cmd_t  push_data,
  input  logic            pop,
  output logic            full,
  output logic            not_empty,
  output clns_pkg::cmd_t  pop_data
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  clns_pkg::cmd_t mem_r [DEPTH];
  logic [AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]  count_r, count_nxt;

  assign full      = (count_r == CW'(DEPTH));
  assign not_empty = (count_r != '0);
  assign pop_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// File: src/clns_back.sv
// back end: walks each command's action list and emits timed pin segments
module clns_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_not_empty,
  input  clns_pkg::cmd_t       q_pop_data,
  output logic                 q_pop,
  input  logic [6:0]           line0_base,
  input  logic [6:0]           line1_base,
  output logic                 out_valid,
  input  logic                 out_ready,
  output clns_pkg::out_word_t  out_data
);

  clns_pkg::back_state_t       state_r, state_nxt;
  clns_pkg::cmd_t              cmd_r, cmd_nxt;
  logic [clns_pkg::PC_W-1:0]   pc_r, pc_nxt;
  logic [1:0]                  seg_r, seg_nxt;
  logic                        select_r, select_nxt;
  logic [3:0]                  nibble_r, nibble_nxt;
  logic                        row_r, row_nxt;
  logic                        out_valid_r, out_valid_nxt;
  clns_pkg::out_word_t         out_word_r, out_word_nxt;

  clns_pkg::act_t              act;
  clns_pkg::out_word_t         word;
  logic                        emit;
  logic                        step_done;
  logic                        slot_free;
  logic                        go;
  logic                        finish;
  logic [clns_pkg::HOLD_W-1:0] byte_end_hold;

  assign act       = clns_pkg::act_decode(cmd_r.kind, pc_r, cmd_r.sel, cmd_r.byte_val);
  assign slot_free = !out_valid_r || out_ready;
  assign go        = (state_r == clns_pkg::BK_RUN) && slot_free;
  assign finish    = go && act.last && step_done;
  assign q_pop     = (state_r == clns_pkg::BK_IDLE) && q_not_empty;

  always_comb begin
    unique case (act.tail)
      clns_pkg::TAIL_INIT:  byte_end_hold = clns_pkg::HOLD_BYTE_END_INIT;
      clns_pkg::TAIL_CLEAR: byte_end_hold = clns_pkg::HOLD_BYTE_END_CLEAR;
      default:              byte_end_hold = clns_pkg::HOLD_BYTE_END;
    endcase
  end

  // segment for the current action step
  always_comb begin
    emit              = 1'b1;
    step_done         = 1'b1;
    word.reg_select   = select_r;
    word.enable_pin   = 1'b0;
    word.bus_value    = nibble_r;
    word.hold_cycles  = clns_pkg::HOLD_SETTLE;
    unique case (act.code)
      clns_pkg::ACT_SETTLE: begin
        emit            = (select_r != act.arg[0]);
        word.reg_select = act.arg[0];
      end
      clns_pkg::ACT_POWERUP: begin
        word.reg_select  = 1'b0;
        word.bus_value   = 4'h0;
        word.hold_cycles = clns_pkg::HOLD_POWERUP;
      end
      clns_pkg::ACT_NIBBLE: begin
        step_done        = seg_r[0];
        word.enable_pin  = !seg_r[0];
        word.bus_value   = act.arg[3:0];
        word.hold_cycles = seg_r[0] ? clns_pkg::HOLD_INIT_PULSE_END
                                    : clns_pkg::HOLD_INIT_PULSE;
      end
      clns_pkg::ACT_BYTE: begin
        step_done        = (seg_r == 2'd3);
        word.enable_pin  = !seg_r[0];
        word.bus_value   = seg_r[1] ? act.arg[3:0] : act.arg[7:4];
        word.hold_cycles = (seg_r == 2'd3) ? byte_end_hold : clns_pkg::HOLD_PULSE;
      end
    endcase
    word.last_segment = act.last && step_done;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      clns_pkg::BK_IDLE: if (q_not_empty) state_nxt = clns_pkg::BK_RUN;
      clns_pkg::BK_RUN:  if (finish) state_nxt = clns_pkg::BK_IDLE;
    endcase
  end

  // datapath and output register
  always_comb begin
    cmd_nxt       = cmd_r;
    pc_nxt        = pc_r;
    seg_nxt       = seg_r;
    select_nxt    = select_r;
    nibble_nxt    = nibble_r;
    row_nxt       = row_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && !out_ready;
    if (q_pop) begin
      cmd_nxt = q_pop_data;
      pc_nxt  = '0;
      seg_nxt = '0;
      unique case (q_pop_data.kind)
        clns_pkg::KIND_INIT, clns_pkg::KIND_CLEAR: row_nxt = 1'b0;
        clns_pkg::KIND_BYTE: if (q_pop_data.set_row) row_nxt = q_pop_data.row;
        clns_pkg::KIND_NEWLINE: begin
          row_nxt          = !row_r;
          cmd_nxt.byte_val = {1'b1, row_r ? line0_base : line1_base};
        end
      endcase
    end
    if (go) begin
      if (emit) begin
        out_valid_nxt = 1'b1;
        out_word_nxt  = word;
        nibble_nxt    = word.bus_value;
        select_nxt    = word.reg_select;
      end
      if (step_done) begin
        pc_nxt  = pc_r + 1'b1;
        seg_nxt = '0;
      end else begin
        seg_nxt = seg_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= clns_pkg::BK_IDLE;
      select_r    <= 1'b0;
      nibble_r    <= 4'h0;
      row_r       <= 1'b0;
      out_valid_r <= 1'b0;
      pc_r        <= '0;
      seg_r       <= '0;
    end else begin
      state_r     <= state_nxt;
      select_r    <= select_nxt;
      nibble_r    <= nibble_nxt;
      row_r       <= row_nxt;
      out_valid_r <= out_valid_nxt;
      pc_r        <= pc_nxt;
      seg_r       <= seg_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    out_word_r <= out_word_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

endmodule

// File: src/char_lcd_nibble_sequencer.sv
// top level of the 4-bit character display sequencer
//
//   port group  dir  handshake            carries
//   in_         in   in_valid/in_ready    one command word (clns_pkg::in_word_t)
//   out_        out  out_valid/out_ready  one pin segment word (clns_pkg::out_word_t)
//   cfg_        in   cfg_we               row base address, cfg_index selects the row
//
// a command passes through the queue and is popped in the back end's load step,
// then the action walker emits one segment per cycle while out_ready does not
// stall it; a settle step that is skipped because register select already has
// the wanted level still takes a walker step but emits no segment
// a stalled out_ready holds the segment register and the walker; the front end
// keeps taking words until the queue is full
// reset is synchronous and needs no clearing pass
module char_lcd_nibble_sequencer #(
  parameter int QUEUE_DEPTH = clns_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  clns_pkg::in_word_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output clns_pkg::out_word_t  out_data,
  input  logic                 cfg_we,
  input  logic                 cfg_index,
  input  logic [6:0]           cfg_data
);

  // row base address registers
  logic [6:0] line0_base_r, line0_base_nxt;
  logic [6:0] line1_base_r, line1_base_nxt;

  // front to queue
  logic           q_push;
  clns_pkg::cmd_t q_push_data;
  logic           q_full;

  // queue to back
  logic           q_pop;
  logic           q_not_empty;
  clns_pkg::cmd_t q_pop_data;

  always_comb begin
    line0_base_nxt = line0_base_r;
    line1_base_nxt = line1_base_r;
    if (cfg_we) begin
      unique case (cfg_index)
        clns_pkg::REG_LINE0_BASE: line0_base_nxt = cfg_data;
        clns_pkg::REG_LINE1_BASE: line1_base_nxt = cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line0_base_r <= clns_pkg::LINE0_BASE_RST;
      line1_base_r <= clns_pkg::LINE1_BASE_RST;
    end else begin
      line0_base_r <= line0_base_nxt;
      line1_base_r <= line1_base_nxt;
    end
  end

  // classify: goto address is formed here, undefined ops are dropped
  clns_front u_front (
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_data     (in_data),
    .line0_base  (line0_base_r),
    .line1_base  (line1_base_r),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_push_data (q_push_data)
  );

  // decouples command intake from the slow segment stream
  clns_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .pop_data  (q_pop_data)
  );

  // owns register select, held nibble and cursor row
  clns_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_pop_data  (q_pop_data),
    .q_pop       (q_pop),
    .line0_base  (line0_base_r),
    .line1_base  (line1_base_r),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_data    (out_data)
  );

endmodule

// File: src/clns_checker.sv
// port-level checks on the display sequencer and their binding
module clns_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_ready,
  input clns_pkg::in_word_t   in_data,
  input logic                 out_valid,
  input logic                 out_ready,
  input clns_pkg::out_word_t  out_data,
  input logic                 cfg_we,
  input logic                 cfg_index,
  input logic [6:0]           cfg_data
);

  // a stalled segment word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("segment word changed while stalled");

  // no segment right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("segment word valid after reset");

  // an enable strobe is short and never ends a command
  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.enable_pin |->
      !out_data.last_segment &&
      (out_data.hold_cycles == 21'd100 || out_data.hold_cycles == 21'd80))
    else $error("bad enable strobe segment");

  // power-up wait has all pins low
  a_powerup: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.hold_cycles == 21'd1550000 |->
      !out_data.reg_select && !out_data.enable_pin && out_data.bus_value == 4'h0)
    else $error("power-up segment drives pins");

endmodule

bind char_lcd_nibble_sequencer clns_checker u_clns_checker (.*);
